FILE: rtl/rcpw_pkg.sv
package rcpw_pkg;

  localparam int PIN_BITS = 5;
  localparam int TIME_W = 32;
  localparam int WIDTH_W = 16;
  localparam int CHAN_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'd1;

  localparam logic [WIDTH_W-1:0] RESET_MIN_WIDTH = 16'd900;
  localparam logic [WIDTH_W-1:0] RESET_MAX_WIDTH = 16'd2200;

  typedef struct packed {
    logic [PIN_BITS-1:0] pin_levels;
    logic [TIME_W-1:0]   time_us;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } out_t;

  // what one lane found for the sample being accepted
  typedef struct packed {
    logic               hit;
    logic [WIDTH_W-1:0] width;
  } lane_res_t;

endpackage

FILE: rtl/rc_pulse_width_capture_top.sv
// channel  | ports                                  | moves
// ---------+----------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data            | pin sample with timestamp
// result   | out_valid, out_ready, out_data         | channel, width, last
// config   | cfg_we, cfg_index, cfg_wdata           | min_width (0), max_width (1)
//
// a sample is taken every cycle while it and the one before cause at most one result;
// a sample with more than one accepted pulse holds in_ready low while its results leave,
// as the result register sends one result per cycle while out_ready lets it. edges are
// found in the lanes at accept time, so a result passes through the pending group and
// then the result register. rst_n is synchronous; out_ready low stalls the result
// register and, while a pending group cannot drain, the input side.
module rc_pulse_width_capture_top #(
  parameter int CHANNELS = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rcpw_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rcpw_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpw_pkg::WIDTH_W-1:0]       cfg_wdata
);
  import rcpw_pkg::*;

  // only pins that exist can ever show an edge
  localparam int LANES = (CHANNELS < PIN_BITS) ? CHANNELS : PIN_BITS;

  logic [WIDTH_W-1:0] min_r;
  logic [WIDTH_W-1:0] max_r;
  logic               accept;
  logic               slot_free;
  lane_res_t          res [LANES];

  assign in_ready = slot_free;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= RESET_MIN_WIDTH;
      max_r <= RESET_MAX_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_WIDTH: min_r <= cfg_wdata;
        REG_MAX_WIDTH: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rcpw_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (accept),
      .pin       (in_data.pin_levels[g]),
      .time_us   (in_data.time_us),
      .min_width (min_r),
      .max_width (max_r),
      .res       (res[g])
    );
  end

  rcpw_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/rcpw_lane.sv
module rcpw_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            pin,
  input  logic [rcpw_pkg::TIME_W-1:0]     time_us,
  input  logic [rcpw_pkg::WIDTH_W-1:0]    min_width,
  input  logic [rcpw_pkg::WIDTH_W-1:0]    max_width,
  output rcpw_pkg::lane_res_t             res
);
  import rcpw_pkg::*;

  logic              prev_r;
  logic [TIME_W-1:0] rise_r;
  logic [TIME_W-1:0] diff;
  logic              fall;
  logic              in_range;

  // wraps modulo 2^32
  assign diff = time_us - rise_r;
  assign fall = prev_r & ~pin;
  assign in_range = ({{(TIME_W-WIDTH_W){1'b0}}, min_width} < diff) &&
                    (diff < {{(TIME_W-WIDTH_W){1'b0}}, max_width});

  always_comb begin
    res.hit = fall & in_range;
    res.width = diff[WIDTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      rise_r <= '0;
    end else if (accept) begin
      prev_r <= pin;
      if (pin && !prev_r) begin
        rise_r <= time_us;
      end
    end
  end

endmodule

FILE: rtl/rcpw_merge.sv
module rcpw_merge #(
  parameter int LANES = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rcpw_pkg::lane_res_t  res [LANES],
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rcpw_pkg::out_t       out_data
);
  import rcpw_pkg::*;

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0]   mask_r;
  logic [LANES-1:0]   mask_nxt;
  logic [WIDTH_W-1:0] wid_r [LANES];
  logic [LANES-1:0]   new_mask;
  logic [LANES-1:0]   rest;
  logic [IDX_W-1:0]   sel;
  logic               grp_valid;
  logic               out_free;
  logic               move;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_data_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      new_mask[i] = res[i].hit;
    end
  end

  // lowest pending channel goes first
  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign rest = mask_r & (mask_r - LANES'(1));
  assign grp_valid = |mask_r;
  assign out_free = !out_valid_r || out_ready;
  assign move = grp_valid && out_free;
  assign slot_free = !grp_valid || (move && (rest == '0));

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = new_mask;
    end else if (move) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LANES; i++) begin
        wid_r[i] <= res[i].width;
      end
    end
    if (move) begin
      out_data_r.channel <= CHAN_W'(sel);
      out_data_r.width <= wid_r[sel];
      out_data_r.last <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcpw_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0] cfg_wdata = '0;

  rc_pulse_width_capture_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [WIDTH_W-1:0] min_w = RESET_MIN_WIDTH;
  logic [WIDTH_W-1:0] max_w = RESET_MAX_WIDTH;
  logic [PIN_BITS-1:0] last_levels = '0;
  logic [TIME_W-1:0] rise_at [PIN_BITS];
  logic [WIDTH_W-1:0] held_w [PIN_BITS];

  in_t sample_q [$];
  out_t width_q [$];

  int err_cnt = 0;
  int cycles = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 84;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit long_hold_arm = 1'b0;

  // stimulus generator state
  logic [TIME_W-1:0] gen_t = '0;
  int gen_count = 0;

  initial begin
    for (int c = 0; c < PIN_BITS; c++) begin
      rise_at[c] = '0;
      held_w[c] = 16'd1502;
    end
  end

  function automatic void predict_widths(input in_t s);
    logic [PIN_BITS-1:0] changed;
    logic [TIME_W-1:0] d;
    out_t r;
    int n;
    changed = s.pin_levels ^ last_levels;
    n = 0;
    for (int c = 0; c < PIN_BITS; c++) begin
      if (changed[c]) begin
        if (s.pin_levels[c]) begin
          rise_at[c] = s.time_us;
        end else begin
          d = s.time_us - rise_at[c];
          // bounds are exclusive and compared on the full 32-bit difference
          if (d > TIME_W'(min_w) && d < TIME_W'(max_w)) begin
            held_w[c] = d[WIDTH_W-1:0];
            r.channel = CHAN_W'(c);
            r.width = held_w[c];
            r.last = 1'b0;
            width_q.push_back(r);
            n++;
          end
        end
      end
    end
    if (n > 0) begin
      r = width_q[width_q.size()-1];
      r.last = 1'b1;
      width_q[width_q.size()-1] = r;
    end
    last_levels = s.pin_levels;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_widths(in_data);
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (width_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result ch %0d width %0d last %0d", $time,
                   out_data.channel, out_data.width, out_data.last);
        end else begin
          want = width_q.pop_front();
          if (out_data.channel !== want.channel || out_data.width !== want.width ||
              out_data.last !== want.last) begin
            err_cnt++;
            $display("%0t: mismatch expected ch %0d width %0d last %0d, ",
                     $time, want.channel, want.width, want.last,
                     "got ch %0d width %0d last %0d",
                     out_data.channel, out_data.width, out_data.last);
          end
        end
      end
      if (long_hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_sample(input logic [PIN_BITS-1:0] levels, input logic [TIME_W-1:0] t);
    in_t s;
    s.pin_levels = levels;
    s.time_us = t;
    sample_q.push_back(s);
    gen_t = t;
    gen_count++;
  endtask

  function automatic logic [31:0] pick_width();
    logic [31:0] lo, hi;
    lo = 32'(min_w);
    hi = 32'(max_w);
    case ($urandom_range(9))
      0: return lo;
      1: return lo + 1;
      2: return hi - 1;
      3: return hi;
      4: return $urandom_range(3000);
      default: return (lo < hi) ? $urandom_range(hi, lo) : $urandom_range(3000);
    endcase
  endfunction

  // rise a set of channels, then drop them in one or two groups
  task automatic add_pulse_frame();
    logic [PIN_BITS-1:0] mask, sub;
    logic [31:0] t0, w1, w2, tmp;
    if ($urandom_range(19) == 0) gen_t = 32'hFFFF_FFFF - $urandom_range(3000);
    mask = PIN_BITS'($urandom_range(31, 1));
    sub = mask & PIN_BITS'($urandom);
    t0 = gen_t + $urandom_range(3000, 1);
    w1 = pick_width();
    w2 = pick_width();
    if (w2 < w1) begin
      tmp = w1;
      w1 = w2;
      w2 = tmp;
    end
    add_sample(mask, t0);
    if (sub != 0 && sub != mask) add_sample(mask & ~sub, t0 + w1);
    add_sample('0, t0 + w2);
  endtask

  task automatic add_noise();
    logic [31:0] t;
    if ($urandom_range(9) == 0) t = $urandom;
    else t = gen_t + $urandom_range(5000);
    add_sample(PIN_BITS'($urandom), t);
  endtask

  task automatic random_samples(input int n);
    gen_count = 0;
    while (gen_count < n) begin
      if ($urandom_range(99) < 75) add_pulse_frame();
      else add_noise();
    end
  endtask

  task automatic write_limits(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_WIDTH;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_WIDTH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_w = lo;
    max_w = hi;
  endtask

  // samples that cause no result may still be in flight, hence the settle time
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || width_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits 900..2200
    add_sample(5'h1F, 32'd100);       // first sample: every high pin is a rise
    add_sample(5'h00, 32'd1001);      // just above min on all channels at once
    add_sample(5'h05, 32'd2000);
    add_sample(5'h00, 32'd2900);      // equal to min, rejected
    add_sample(5'h0A, 32'd3000);
    add_sample(5'h02, 32'd5199);      // just below max
    add_sample(5'h15, 32'd5200);      // equal to max, rejected, plus rises
    add_sample(5'h0A, 32'd6500);      // falls and rises in one sample
    add_sample(5'h00, 32'd6500 + 32'd65536 + 32'd1000);  // upper bits set, rejected
    add_sample(5'h10, 32'hFFFF_FC00);
    add_sample(5'h00, 32'h0000_0300); // width across the timestamp wrap
    add_sample(5'h1F, 32'hFFFF_FFFF);
    add_sample(5'h0F, 32'h0000_0500);
    add_sample(5'h0F, 32'd6000);      // no change, no result
    add_sample(5'h00, 32'd6000);      // too long, rejected
    random_samples(30);
    wait_idle();

    send_idle_pct = 84;
    recv_idle_pct = 23;
    write_limits(16'd0, 16'hFFFF);
    @(negedge clk);
    add_sample(5'h00, 32'd500);
    add_sample(5'h01, 32'd1000);
    add_sample(5'h00, 32'd1000);      // zero width, rejected
    add_sample(5'h01, 32'd1000);
    add_sample(5'h00, 32'd1001);
    add_sample(5'h01, 32'd2000);
    add_sample(5'h00, 32'd2000 + 32'd65534);
    add_sample(5'h01, 32'd100000);
    add_sample(5'h00, 32'd100000 + 32'd65535);
    random_samples(30);
    wait_idle();

    // min above max: nothing accepted
    write_limits(16'hFFFF, 16'd0);
    @(negedge clk);
    random_samples(10);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limits(WIDTH_W'($urandom_range(1100, 800)), WIDTH_W'($urandom_range(2300, 1900)));
    @(negedge clk);
    random_samples(35);
    long_hold_arm = 1'b1;
    wait_idle();

    if (err_cnt == 0 && width_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
